/* hdl/imhq_pkg.sv */
// Shared types and constants for the indexed min-heap queue.
package imhq_pkg;

  localparam int NumHandles = 4096;
  localparam int HeapDepth  = 1024;
  localparam int KeyBits    = 32;
  localparam int HandleW    = $clog2(NumHandles);
  localparam int SlotW      = $clog2(HeapDepth);
  localparam int CountW     = SlotW + 1;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_POP   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    HS_UNVISITED = 2'd0,
    HS_IN_HEAP   = 2'd1,
    HS_DONE      = 2'd2
  } hstat_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_POPPED   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_MOVE,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic map_rd;
    logic ins_write;
    logic upd_write;
    logic up_swap;
    logic pop_rd;
    logic pop_move;
    logic dn_rdl;
    logic dn_rdr;
    logic dn_swap;
    logic place;
    status_e status;
    logic emit;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic   clr_done;
    op_e    op;
    hstat_e hstat;
    logic   slot_ok;
    logic   full;
    logic   empty;
    logic   up_more;
    logic   up_less;
    logic   dn_has_l;
    logic   dn_less;
  } stat_t;

endpackage

/* hdl/imhq_datapath.sv */
// Heap storage, handle map and the sift compare/move datapath.
module imhq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_i,
  input  logic [imhq_pkg::HandleW-1:0] handle_i,
  input  logic [imhq_pkg::KeyBits-1:0] key_i,
  input  imhq_pkg::ctrl_t              ctrl_i,
  output imhq_pkg::stat_t              stat_o,
  output logic                         valid_o,
  output logic [2:0]                   status_o,
  output logic [imhq_pkg::HandleW-1:0] out_handle_o,
  output logic [imhq_pkg::KeyBits-1:0] out_key_o
);
  localparam int HW = imhq_pkg::HandleW;
  localparam int SW = imhq_pkg::SlotW;
  localparam int CW = imhq_pkg::CountW;
  localparam int KW = imhq_pkg::KeyBits;

  // Memories.
  logic [1:0]    hstat_mem [imhq_pkg::NumHandles];
  logic [SW-1:0] hslot_mem [imhq_pkg::NumHandles];
  logic [HW-1:0] shnd_mem  [imhq_pkg::HeapDepth];
  logic [KW-1:0] skey_mem  [imhq_pkg::HeapDepth];

  logic [HW:0]   clr_q;
  logic          op_q;
  logic [HW-1:0] hnd_q;
  logic [KW-1:0] key_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    hstat_rd_q;
  logic [SW-1:0] hslot_rd_q;
  // Moving entry and the hole it currently sits in.
  logic [SW-1:0] cur_q;
  logic [HW-1:0] mh_q;
  logic [KW-1:0] mk_q;
  // Left child held while the right child is read.
  logic [HW-1:0] lh_q;
  logic [KW-1:0] lk_q;
  // Slot memory read data.
  logic [HW-1:0] rdh_q;
  logic [KW-1:0] rdk_q;
  logic [2:0]    st_q;
  logic [HW-1:0] oh_q;
  logic [KW-1:0] ok_q;
  logic          vld_q;
  logic          mv_q;

  logic [SW-1:0] raddr;
  logic [SW-1:0] par;
  logic [CW:0]   lc_w;
  logic [CW:0]   rc_w;
  logic          has_r;
  logic          pick_r;
  logic [SW-1:0] ch_slot;
  logic [HW-1:0] ch_h;
  logic [KW-1:0] ch_k;

  assign par     = (cur_q - SW'(1)) >> 1;
  assign lc_w    = {1'b0, cur_q, 1'b1};
  assign rc_w    = lc_w + (CW+1)'(1);
  assign has_r   = (rc_w < {1'b0, cnt_q});
  // Take the right child only when it is strictly smaller.
  assign pick_r  = has_r && (lk_q > rdk_q);
  assign ch_slot = pick_r ? rc_w[SW-1:0] : lc_w[SW-1:0];
  assign ch_h    = pick_r ? rdh_q : lh_q;
  assign ch_k    = pick_r ? rdk_q : lk_q;

  always_comb begin
    raddr = par;
    if (ctrl_i.pop_rd)   raddr = '0;
    if (ctrl_i.pop_move) raddr = SW'(cnt_q);
    if (ctrl_i.dn_rdl)   raddr = lc_w[SW-1:0];
    if (ctrl_i.dn_rdr)   raddr = rc_w[SW-1:0];
  end

  // Write ports: one per memory per cycle.
  logic          sw_en;
  logic [SW-1:0] sw_addr;
  logic [HW-1:0] sw_h;
  logic [KW-1:0] sw_k;
  logic          hs_en;
  logic [HW-1:0] hs_addr;
  logic [SW-1:0] hs_d;

  always_comb begin
    sw_en   = 1'b0;
    sw_addr = cur_q;
    sw_h    = mh_q;
    sw_k    = mk_q;
    hs_en   = 1'b0;
    hs_addr = mh_q;
    hs_d    = cur_q;
    if (ctrl_i.up_swap) begin
      // Parent drops into the hole.
      sw_en   = 1'b1;
      sw_h    = rdh_q;
      sw_k    = rdk_q;
      hs_en   = 1'b1;
      hs_addr = rdh_q;
    end
    if (ctrl_i.dn_swap) begin
      // Chosen child rises into the hole.
      sw_en   = 1'b1;
      sw_h    = ch_h;
      sw_k    = ch_k;
      hs_en   = 1'b1;
      hs_addr = ch_h;
    end
    if (ctrl_i.place) begin
      sw_en = 1'b1;
      hs_en = 1'b1;
    end
  end

  logic          st_en;
  logic [HW-1:0] st_addr;
  logic [1:0]    st_d;

  always_comb begin
    st_en   = 1'b0;
    st_addr = hnd_q;
    st_d    = imhq_pkg::HS_IN_HEAP;
    if (ctrl_i.clr_step) begin
      st_en   = 1'b1;
      st_addr = clr_q[HW-1:0];
      st_d    = imhq_pkg::HS_UNVISITED;
    end
    if (ctrl_i.ins_write) st_en = 1'b1;
    if (ctrl_i.pop_move) begin
      // Root handle is on the read data now.
      st_en   = 1'b1;
      st_addr = rdh_q;
      st_d    = imhq_pkg::HS_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_en) hstat_mem[st_addr] <= st_d;
    if (ctrl_i.map_rd) hstat_rd_q <= hstat_mem[hnd_q];
  end

  always_ff @(posedge clk_i) begin
    if (hs_en) hslot_mem[hs_addr] <= hs_d;
    if (ctrl_i.map_rd) hslot_rd_q <= hslot_mem[hnd_q];
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      shnd_mem[sw_addr] <= sw_h;
      skey_mem[sw_addr] <= sw_k;
    end
    rdh_q <= shnd_mem[raddr];
    rdk_q <= skey_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
      mv_q  <= 1'b0;
      st_q  <= imhq_pkg::ST_IGNORED;
      oh_q  <= '0;
      ok_q  <= '0;
    end else begin
      vld_q <= ctrl_i.emit;
      mv_q  <= ctrl_i.pop_move;
      if (ctrl_i.clr_step) clr_q <= clr_q + (HW+1)'(1);
      if (ctrl_i.ins_write) cnt_q <= cnt_q + CW'(1);
      if (ctrl_i.pop_rd) cnt_q <= cnt_q - CW'(1);
      if (ctrl_i.capture) begin
        oh_q <= '0;
        ok_q <= '0;
      end
      if (ctrl_i.pop_move) begin
        oh_q <= rdh_q;
        ok_q <= rdk_q;
      end
      if (ctrl_i.emit) st_q <= ctrl_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      op_q  <= op_i;
      hnd_q <= handle_i;
      key_q <= key_i;
    end
    if (ctrl_i.ins_write) begin
      cur_q <= SW'(cnt_q);
      mh_q  <= hnd_q;
      mk_q  <= key_q;
    end
    if (ctrl_i.upd_write) begin
      cur_q <= hslot_rd_q;
      mh_q  <= hnd_q;
      mk_q  <= key_q;
    end
    if (ctrl_i.up_swap) cur_q <= par;
    if (ctrl_i.pop_move) cur_q <= '0;
    // Last entry arrives in the cycle after pop_move.
    if (mv_q) begin
      mh_q <= rdh_q;
      mk_q <= rdk_q;
    end
    if (ctrl_i.dn_rdr) begin
      lh_q <= rdh_q;
      lk_q <= rdk_q;
    end
    if (ctrl_i.dn_swap) cur_q <= ch_slot;
  end

  assign stat_o.clr_done = clr_q[HW];
  assign stat_o.op       = imhq_pkg::op_e'(op_q);
  assign stat_o.hstat    = imhq_pkg::hstat_e'(hstat_rd_q);
  assign stat_o.slot_ok  = (CW'(hslot_rd_q) < cnt_q);
  assign stat_o.full     = (cnt_q == CW'(imhq_pkg::HeapDepth));
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.up_more  = (cur_q != '0);
  assign stat_o.up_less  = (mk_q < rdk_q);
  assign stat_o.dn_has_l = (lc_w < {1'b0, cnt_q});
  assign stat_o.dn_less  = (ch_k < mk_q);

  assign valid_o      = vld_q;
  assign status_o     = st_q;
  assign out_handle_o = oh_q;
  assign out_key_o    = ok_q;
endmodule

/* hdl/imhq_ctrl.sv */
// Sequencer for offer, pop and the sift loops.
module imhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  imhq_pkg::stat_t stat_i,
  output imhq_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  imhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= imhq_pkg::S_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      imhq_pkg::S_CLEAR:   if (stat_i.clr_done) state_d = imhq_pkg::S_IDLE;
      imhq_pkg::S_IDLE:    if (start_i) state_d = imhq_pkg::S_LOOKUP;
      imhq_pkg::S_LOOKUP:  state_d = imhq_pkg::S_DECIDE;
      imhq_pkg::S_DECIDE: begin
        if (stat_i.op == imhq_pkg::OP_POP) begin
          state_d = stat_i.empty ? imhq_pkg::S_DONE : imhq_pkg::S_POP_RD;
        end else if (stat_i.hstat == imhq_pkg::HS_IN_HEAP) begin
          state_d = stat_i.slot_ok ? imhq_pkg::S_UP_RD : imhq_pkg::S_DONE;
        end else if (stat_i.hstat == imhq_pkg::HS_UNVISITED && !stat_i.full) begin
          state_d = imhq_pkg::S_UP_RD;
        end else begin
          state_d = imhq_pkg::S_DONE;
        end
      end
      imhq_pkg::S_UP_RD:   state_d = stat_i.up_more ? imhq_pkg::S_UP_CMP : imhq_pkg::S_DONE;
      imhq_pkg::S_UP_CMP:  state_d = stat_i.up_less ? imhq_pkg::S_UP_RD : imhq_pkg::S_DONE;
      imhq_pkg::S_POP_RD:  state_d = imhq_pkg::S_POP_MOVE;
      imhq_pkg::S_POP_MOVE: state_d = imhq_pkg::S_DN_RDL;
      imhq_pkg::S_DN_RDL:  state_d = stat_i.dn_has_l ? imhq_pkg::S_DN_RDR : imhq_pkg::S_DONE;
      imhq_pkg::S_DN_RDR:  state_d = imhq_pkg::S_DN_CMP;
      imhq_pkg::S_DN_CMP:  state_d = stat_i.dn_less ? imhq_pkg::S_DN_RDL : imhq_pkg::S_DONE;
      imhq_pkg::S_DONE:    state_d = imhq_pkg::S_IDLE;
      default:             state_d = imhq_pkg::S_IDLE;
    endcase
  end

  // Result kind and whether the moving entry gets written back, latched at decision.
  imhq_pkg::status_e res_q, res_d;
  logic place_q, place_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= imhq_pkg::ST_IGNORED;
      place_q <= 1'b0;
    end else if (state_q == imhq_pkg::S_DECIDE) begin
      res_q   <= res_d;
      place_q <= place_d;
    end
  end

  always_comb begin
    res_d   = imhq_pkg::ST_IGNORED;
    place_d = 1'b0;
    if (stat_i.op == imhq_pkg::OP_POP) begin
      res_d   = stat_i.empty ? imhq_pkg::ST_EMPTY : imhq_pkg::ST_POPPED;
      place_d = !stat_i.empty;
    end else if (stat_i.hstat == imhq_pkg::HS_IN_HEAP) begin
      res_d   = imhq_pkg::ST_UPDATED;
      place_d = stat_i.slot_ok;
    end else if (stat_i.hstat == imhq_pkg::HS_UNVISITED) begin
      res_d   = stat_i.full ? imhq_pkg::ST_FULL : imhq_pkg::ST_INSERTED;
      place_d = !stat_i.full;
    end
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.status   = res_q;
    ctrl_o.clr_step = (state_q == imhq_pkg::S_CLEAR) && !stat_i.clr_done;
    ctrl_o.capture  = (state_q == imhq_pkg::S_IDLE) && start_i;
    ctrl_o.map_rd   = (state_q == imhq_pkg::S_LOOKUP);
    if (state_q == imhq_pkg::S_DECIDE && stat_i.op == imhq_pkg::OP_OFFER) begin
      ctrl_o.ins_write = (stat_i.hstat == imhq_pkg::HS_UNVISITED) && !stat_i.full;
      ctrl_o.upd_write = (stat_i.hstat == imhq_pkg::HS_IN_HEAP) && stat_i.slot_ok;
    end
    ctrl_o.up_swap  = (state_q == imhq_pkg::S_UP_CMP) && stat_i.up_less;
    ctrl_o.pop_rd   = (state_q == imhq_pkg::S_POP_RD);
    ctrl_o.pop_move = (state_q == imhq_pkg::S_POP_MOVE);
    ctrl_o.dn_rdl   = (state_q == imhq_pkg::S_DN_RDL);
    ctrl_o.dn_rdr   = (state_q == imhq_pkg::S_DN_RDR);
    ctrl_o.dn_swap  = (state_q == imhq_pkg::S_DN_CMP) && stat_i.dn_less;
    ctrl_o.place    = (state_q == imhq_pkg::S_DONE) && place_q;
    ctrl_o.emit     = (state_q == imhq_pkg::S_DONE);
  end

  assign busy_o = (state_q != imhq_pkg::S_IDLE);
endmodule

/* hdl/indexed_min_heap_queue_core.sv */
// Top level of the indexed binary min-heap queue.
// One command at a time: start is taken while busy is low, and exactly one
// result follows, shown for one cycle with valid_o high in the first cycle
// that busy is low again; the receiver cannot stall it. After reset the
// handle map is swept clear with busy high. An ignored, full or empty
// command then goes through lookup, decide and done; an offer adds a
// parent read and key compare per level it checks, and a pop adds the root
// read, the move of the last entry to the root, and a left read, right
// read and compare per child pair it checks. Every level goes through the
// slot memories, which have one read and one write port each.
module indexed_min_heap_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [11:0] handle_i,
  input  logic [31:0] key_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic [11:0] out_handle_o,
  output logic [31:0] out_key_o
);
  imhq_pkg::ctrl_t ctrl;
  imhq_pkg::stat_t stat;

  imhq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  imhq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (opcode_i),
    .handle_i    (handle_i),
    .key_i       (key_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .out_handle_o(out_handle_o),
    .out_key_o   (out_key_o)
  );
endmodule

/* hdl/imhq_checker.sv */
// Port-level checks for the heap queue, bound to the top level.
module imhq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [2:0]  status_o,
  input logic [11:0] out_handle_o,
  input logic [31:0] out_key_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy)) else $error("result without command");
  a_status_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o <= imhq_pkg::ST_EMPTY)) else $error("bad status");
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != imhq_pkg::ST_POPPED) |->
      (out_handle_o == '0 && out_key_o == '0))
    else $error("payload on non-pop");
endmodule

bind indexed_min_heap_queue_core imhq_checker u_imhq_checker (.*);

/* sim/indexed_min_heap_queue_core_tb.sv */
// Testbench for the indexed min-heap queue: checks every result beat against a heap predictor.
`timescale 1ns / 1ps

module indexed_min_heap_queue_core_tb;

  typedef struct {
    imhq_pkg::op_e     op;
    logic [11:0]       hdl;
    logic [31:0]       key;
  } cmd_t;

  typedef struct {
    imhq_pkg::status_e status;
    logic [11:0]       hdl;
    logic [31:0]       key;
  } answer_t;

  localparam int IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [11:0] handle_i;
  logic [31:0] key_i;
  logic        valid_o;
  logic [2:0]  status_o;
  logic [11:0] out_handle_o;
  logic [31:0] out_key_o;

  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  int      errors;
  int      taken;
  int      quiet_cycles;
  logic    took_beat;

  // Predictor state
  imhq_pkg::hstat_e map_st[imhq_pkg::NumHandles];
  int               map_slot[imhq_pkg::NumHandles];
  logic [11:0]      heap_hdl[imhq_pkg::HeapDepth];
  logic [31:0]      heap_key[imhq_pkg::HeapDepth];
  int               heap_cnt;

  indexed_min_heap_queue_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .handle_i     (handle_i),
    .key_i        (key_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .out_handle_o (out_handle_o),
    .out_key_o    (out_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic swap_slots(input int a, input int b);
    logic [11:0] h;
    logic [31:0] k;
    h = heap_hdl[a];
    k = heap_key[a];
    heap_hdl[a] = heap_hdl[b];
    heap_key[a] = heap_key[b];
    heap_hdl[b] = h;
    heap_key[b] = k;
    map_slot[heap_hdl[a]] = a;
    map_slot[heap_hdl[b]] = b;
  endtask

  task automatic climb(input int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_key[i] >= heap_key[p]) break;
      swap_slots(i, p);
      i = p;
    end
  endtask

  task automatic sink(input int i);
    int c;
    forever begin
      c = 2 * i + 1;
      if (c >= heap_cnt) break;
      if (c + 1 < heap_cnt && heap_key[c] > heap_key[c + 1]) c++;
      if (heap_key[i] <= heap_key[c]) break;
      swap_slots(i, c);
      i = c;
    end
  endtask

  task automatic heap_apply(input cmd_t c, output answer_t a);
    int s;
    a.status = imhq_pkg::ST_IGNORED;
    a.hdl    = '0;
    a.key    = '0;
    if (c.op == imhq_pkg::OP_OFFER) begin
      if (map_st[c.hdl] == imhq_pkg::HS_IN_HEAP) begin
        s = map_slot[c.hdl];
        heap_key[s] = c.key;
        climb(s);
        a.status = imhq_pkg::ST_UPDATED;
      end else if (map_st[c.hdl] == imhq_pkg::HS_UNVISITED) begin
        if (heap_cnt >= imhq_pkg::HeapDepth) begin
          a.status = imhq_pkg::ST_FULL;
        end else begin
          s = heap_cnt;
          heap_cnt++;
          heap_hdl[s] = c.hdl;
          heap_key[s] = c.key;
          map_slot[c.hdl] = s;
          map_st[c.hdl] = imhq_pkg::HS_IN_HEAP;
          climb(s);
          a.status = imhq_pkg::ST_INSERTED;
        end
      end
    end else if (heap_cnt == 0) begin
      a.status = imhq_pkg::ST_EMPTY;
    end else begin
      a.status = imhq_pkg::ST_POPPED;
      a.hdl = heap_hdl[0];
      a.key = heap_key[0];
      heap_cnt--;
      if (heap_cnt > 0) begin
        heap_hdl[0] = heap_hdl[heap_cnt];
        heap_key[0] = heap_key[heap_cnt];
        map_slot[heap_hdl[0]] = 0;
      end
      map_st[a.hdl] = imhq_pkg::HS_DONE;
      sink(0);
    end
  endtask

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_cmd(input imhq_pkg::op_e op, input logic [11:0] h,
                          input logic [31:0] k);
    cmd_t c;
    c.op  = op;
    c.hdl = h;
    c.key = k;
    cmd_q.push_back(c);
  endtask

  // Accept command beats, predict, and check result beats.
  always @(posedge clk_i) begin
    cmd_t    c;
    answer_t a;
    answer_t got;
    took_beat = 1'b0;
    if (rst_ni && start && !busy) begin
      c.op  = imhq_pkg::op_e'(opcode_i);
      c.hdl = handle_i;
      c.key = key_i;
      heap_apply(c, a);
      answer_q.push_back(a);
      took_beat = 1'b1;
    end
    if (rst_ni && valid_o) begin
      got.status = imhq_pkg::status_e'(status_o);
      got.hdl    = out_handle_o;
      got.key    = out_key_o;
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected result status %0d", status_o));
      end else begin
        a = answer_q.pop_front();
        if (got.status != a.status)
          report($sformatf("status %0d, want %0d", got.status, a.status));
        if (got.hdl != a.hdl)
          report($sformatf("handle %0h, want %0h", got.hdl, a.hdl));
        if (got.key != a.key)
          report($sformatf("key %0h, want %0h", got.key, a.key));
      end
    end
    if (took_beat || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= IdleLimit) begin
      $display("indexed_min_heap_queue_core_tb failed");
      $finish;
    end
  end

  // Drive command beats on the falling edge; hold a beat until it is taken.
  always @(negedge clk_i) begin
    int   pct;
    logic go;
    if (rst_ni) begin
      if (took_beat) begin
        void'(cmd_q.pop_front());
        taken++;
      end
      if (taken < 633) pct = 34;
      else if (taken < 1266) pct = 78;
      else pct = 0;
      if (start && !took_beat) go = 1'b1;
      else go = cmd_q.size() > 0 && $urandom_range(99) >= pct;
      if (go) begin
        start    <= 1'b1;
        opcode_i <= cmd_q[0].op;
        handle_i <= cmd_q[0].hdl;
        key_i    <= cmd_q[0].key;
      end else begin
        start    <= 1'b0;
      end
    end
  end

  initial begin
    int   fresh;
    logic [31:0] k;
    errors       = 0;
    taken        = 0;
    quiet_cycles = 0;
    took_beat    = 1'b0;
    heap_cnt     = 0;
    foreach (map_st[i]) map_st[i] = imhq_pkg::HS_UNVISITED;
    rst_ni   = 1'b0;
    start    = 1'b0;
    opcode_i = 1'b0;
    handle_i = '0;
    key_i    = '0;

    // Directed: empty pop, extremes, tie, decrease and increase of a key, done handle
    push_cmd(imhq_pkg::OP_POP, 12'hfff, 32'hffff_ffff);
    push_cmd(imhq_pkg::OP_OFFER, 12'h000, 32'h0000_0000);
    push_cmd(imhq_pkg::OP_OFFER, 12'hfff, 32'hffff_ffff);
    push_cmd(imhq_pkg::OP_OFFER, 12'h005, 32'd100);
    push_cmd(imhq_pkg::OP_OFFER, 12'h006, 32'd100);
    push_cmd(imhq_pkg::OP_OFFER, 12'h007, 32'd100);
    push_cmd(imhq_pkg::OP_OFFER, 12'h006, 32'd50);
    push_cmd(imhq_pkg::OP_OFFER, 12'h000, 32'd200);
    push_cmd(imhq_pkg::OP_OFFER, 12'h008, 32'd1);
    push_cmd(imhq_pkg::OP_POP, 12'h000, 32'h0);
    push_cmd(imhq_pkg::OP_OFFER, 12'h008, 32'd3);
    repeat (7) push_cmd(imhq_pkg::OP_POP, 12'h000, 32'h0);
    push_cmd(imhq_pkg::OP_OFFER, 12'hfff, 32'h1);

    // Random mix over a narrow handle range so updates and done hits are common
    repeat (650) begin
      k = ($urandom_range(3) == 0) ? 32'($urandom_range(15)) : $urandom;
      if ($urandom_range(99) < 55)
        push_cmd(imhq_pkg::OP_OFFER, 12'($urandom_range(511)), k);
      else
        push_cmd(imhq_pkg::OP_POP, 12'($urandom), $urandom);
    end

    // Fill past full with fresh handles, mixing in a few updates
    fresh = 1024;
    repeat (1080) begin
      k = ($urandom_range(7) == 0) ? 32'($urandom_range(31)) : $urandom;
      if ($urandom_range(19) == 0) begin
        push_cmd(imhq_pkg::OP_OFFER, 12'($urandom_range(fresh - 1, 1024)), k);
      end else begin
        push_cmd(imhq_pkg::OP_OFFER, 12'(fresh), k);
        fresh++;
      end
    end

    // Drain with deep sift-downs
    repeat (150) push_cmd(imhq_pkg::OP_POP, 12'($urandom), $urandom);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_q.size() == 0 && answer_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("indexed_min_heap_queue_core_tb passed");
    else $display("indexed_min_heap_queue_core_tb failed");
    $finish;
  end

endmodule
